[hdl/cfs_pkg.sv]
// Shared types and constants for the CSV field splitter.
`timescale 1ns / 1ps
package cfs_pkg;

   localparam logic [7:0] QUOTE_BYTE = 8'h22;
   localparam logic [7:0] COMMA_BYTE = 8'h2C;

   localparam logic [1:0] KIND_DATA      = 2'd0;
   localparam logic [1:0] KIND_FIELD_END = 2'd1;
   localparam logic [1:0] KIND_LINE_END  = 2'd2;

   // What an input item does once it has been decoded against the current flags.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LINE_END,
      ACT_FIELD_END,
      ACT_PUSH,
      ACT_OVERFLOW,
      ACT_FLUSH
   } action_type;

   // Source of the result loaded into the output register.
   typedef enum logic [1:0] {
      EMIT_CTRL,
      EMIT_HELD,
      EMIT_OVF,
      EMIT_CHAR
   } emit_sel_type;

   typedef struct packed {
      logic         accept;
      logic         emit;
      emit_sel_type emit_sel;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       count_zero;
      logic       count_one;
      logic       slot_free;
   } status_type;

endpackage

[hdl/cfs_if.sv]
// Valid/ready channel interfaces for the CSV field splitter input and result streams.
`timescale 1ns / 1ps
interface cfs_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] char_byte;

   modport source (output valid, output op, output char_byte, input ready);
   modport sink   (input valid, input op, input char_byte, output ready);
endinterface

interface cfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic       trim_overflow;
   logic       last_of_run;

   modport source (output valid, output kind, output data_byte, output trim_overflow,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input data_byte, input trim_overflow,
                   input last_of_run, output ready);
endinterface

[hdl/cfs_datapath.sv]
// Datapath of the CSV field splitter: parser flags, whitespace hold buffer, output register.
`timescale 1ns / 1ps
module cfs_datapath #(
   parameter int HELD_SPACE_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_op,
   input  logic [7:0]          req_char_byte,
   input  cfs_pkg::cmd_type    cmd,
   output cfs_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_trim_overflow,
   output logic                rsp_last_of_run
);
   import cfs_pkg::*;

   localparam int IW = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;
   localparam int CW = $clog2(HELD_SPACE_DEPTH + 1);

   logic          quoted_ff, quoted_in;
   logic          pending_ff, pending_in;
   logic          started_ff, started_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] head_ff, head_in;
   logic [7:0]    char_ff;
   logic          line_end_ff;
   logic [7:0]    rd_data_ff;
   logic [7:0]    held_mem [HELD_SPACE_DEPTH];

   logic          out_valid_ff;
   logic [1:0]    out_kind_ff;
   logic [7:0]    out_data_ff;
   logic          out_ovf_ff;
   logic          out_last_ff;

   logic          is_quote, is_comma, is_ws, quoted_eff;
   action_type    action;
   logic [IW-1:0] head_inc;
   logic [IW:0]   tail_sum;
   logic [IW-1:0] tail;
   logic          slot_free;

   assign is_quote = (req_char_byte == QUOTE_BYTE);
   assign is_comma = (req_char_byte == COMMA_BYTE);
   assign is_ws    = (req_char_byte == 8'd32) ||
                     ((req_char_byte >= 8'd9) && (req_char_byte <= 8'd13));
   // A pending quote that is not followed by a second quote closes the quoted section.
   assign quoted_eff = pending_ff ? 1'b0 : quoted_ff;

   always_comb begin
      action = ACT_NONE;
      if (req_op) begin
         action = ACT_LINE_END;
      end else if (pending_ff && is_quote) begin
         action = ACT_FLUSH;
      end else if (is_quote) begin
         action = ACT_NONE;
      end else if (is_comma && !quoted_eff) begin
         action = ACT_FIELD_END;
      end else if (!is_ws) begin
         action = ACT_FLUSH;
      end else if (!started_ff) begin
         action = ACT_NONE;
      end else if (count_ff < CW'(HELD_SPACE_DEPTH)) begin
         action = ACT_PUSH;
      end else begin
         action = ACT_OVERFLOW;
      end
   end

   assign head_inc = (head_ff == IW'(HELD_SPACE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_sum = (IW + 1)'(head_ff) + (IW + 1)'(count_ff);
   assign tail     = (tail_sum >= (IW + 1)'(HELD_SPACE_DEPTH)) ?
                     IW'(tail_sum - (IW + 1)'(HELD_SPACE_DEPTH)) : IW'(tail_sum);

   assign slot_free = !out_valid_ff || rsp_ready;

   assign status.action     = action;
   assign status.count_zero = (count_ff == '0);
   assign status.count_one  = (count_ff == CW'(1));
   assign status.slot_free  = slot_free;

   always_comb begin
      quoted_in  = quoted_ff;
      pending_in = pending_ff;
      started_in = started_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      if (cmd.accept) begin
         if (req_op) begin
            quoted_in  = 1'b0;
            pending_in = 1'b0;
         end else if (pending_ff && is_quote) begin
            pending_in = 1'b0;
         end else begin
            quoted_in  = quoted_eff;
            pending_in = 1'b0;
            if (is_quote) begin
               if (quoted_eff) begin
                  pending_in = 1'b1;
               end else begin
                  quoted_in = 1'b1;
               end
            end
         end
         case (action)
            ACT_LINE_END, ACT_FIELD_END: begin
               started_in = 1'b0;
               count_in   = '0;
               head_in    = '0;
            end
            ACT_PUSH:     count_in   = count_ff + 1'b1;
            ACT_OVERFLOW: head_in    = head_inc;
            ACT_FLUSH:    started_in = 1'b1;
            default:      ;
         endcase
      end else if (cmd.emit && (cmd.emit_sel == EMIT_HELD)) begin
         count_in = count_ff - 1'b1;
         head_in  = head_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quoted_ff  <= 1'b0;
         pending_ff <= 1'b0;
         started_ff <= 1'b0;
         count_ff   <= '0;
         head_ff    <= '0;
      end else begin
         quoted_ff  <= quoted_in;
         pending_ff <= pending_in;
         started_ff <= started_in;
         count_ff   <= count_in;
         head_ff    <= head_in;
      end
   end

   // Hold buffer: a ring of whitespace bytes, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.accept && (action == ACT_PUSH)) begin
         held_mem[tail] <= req_char_byte;
      end else if (cmd.accept && (action == ACT_OVERFLOW)) begin
         held_mem[head_ff] <= req_char_byte;
      end
      if (cmd.accept) begin
         rd_data_ff <= held_mem[head_ff];
      end else if (cmd.emit && (cmd.emit_sel == EMIT_HELD)) begin
         rd_data_ff <= held_mem[head_inc];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff     <= req_char_byte;
         line_end_ff <= req_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         case (cmd.emit_sel)
            EMIT_CTRL: begin
               out_kind_ff <= line_end_ff ? KIND_LINE_END : KIND_FIELD_END;
               out_data_ff <= '0;
               out_ovf_ff  <= 1'b0;
               out_last_ff <= 1'b1;
            end
            EMIT_HELD: begin
               out_kind_ff <= KIND_DATA;
               out_data_ff <= rd_data_ff;
               out_ovf_ff  <= 1'b0;
               out_last_ff <= 1'b0;
            end
            EMIT_OVF: begin
               out_kind_ff <= KIND_DATA;
               out_data_ff <= rd_data_ff;
               out_ovf_ff  <= 1'b1;
               out_last_ff <= 1'b1;
            end
            default: begin
               out_kind_ff <= KIND_DATA;
               out_data_ff <= char_ff;
               out_ovf_ff  <= 1'b0;
               out_last_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_data_byte     = out_data_ff;
   assign rsp_trim_overflow = out_ovf_ff;
   assign rsp_last_of_run   = out_last_ff;

endmodule

[hdl/cfs_ctrl.sv]
// Controller of the CSV field splitter: sequences item intake and result emission.
`timescale 1ns / 1ps
module cfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cfs_pkg::status_type status,
   output cfs_pkg::cmd_type    cmd
);
   import cfs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CTRL,
      S_HELD,
      S_OVF,
      S_CHAR
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cmd.accept   = accept;
      cmd.emit     = 1'b0;
      cmd.emit_sel = EMIT_CTRL;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (status.action)
                  ACT_LINE_END, ACT_FIELD_END: state_in = S_CTRL;
                  ACT_OVERFLOW:                state_in = S_OVF;
                  ACT_FLUSH:                   state_in = status.count_zero ? S_CHAR : S_HELD;
                  default:                     state_in = S_IDLE;
               endcase
            end
         end
         S_CTRL: begin
            cmd.emit_sel = EMIT_CTRL;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_HELD: begin
            cmd.emit_sel = EMIT_HELD;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               if (status.count_one) begin
                  state_in = S_CHAR;
               end
            end
         end
         S_OVF: begin
            cmd.emit_sel = EMIT_OVF;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CHAR: begin
            cmd.emit_sel = EMIT_CHAR;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/csv_field_splitter_top.sv]
// CSV field splitter top level: quoted-field tokenizer with per-field whitespace trimming.
// Each result is registered: the transfer of the item that causes it moves the controller
// to an emit state, which loads the result into the output register once that is free.
// The block takes no new item until every result of the last one is loaded. Held bytes
// leave by the hold buffer's single read port, one per cycle while the output is free.
// Reset (synchronous, active high) clears the parser flags, hold count, controller and output.
`timescale 1ns / 1ps
module csv_field_splitter_top #(
   parameter int HELD_SPACE_DEPTH = 32
) (
   input logic    clock,
   input logic    reset,
   cfs_req_if.sink   req_if,
   cfs_rsp_if.source rsp_if
);
   import cfs_pkg::*;

   // The controller and the datapath talk only through these two bundles.
   cmd_type    cmd;
   status_type status;

   // The controller takes one item at a time. An item is accepted only while nothing of
   // the previous item is left to send, apart from a result that still waits in the
   // output register; that register keeps the result stream independent of the input.
   cfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath decodes the presented byte against the quote and field flags, keeps
   // interior whitespace in a ring buffer until a later content byte releases it, and
   // holds the output register. Held bytes are discarded at a field or line end.
   cfs_datapath #(
      .HELD_SPACE_DEPTH (HELD_SPACE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_if.op),
      .req_char_byte     (req_if.char_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .rsp_kind          (rsp_if.kind),
      .rsp_data_byte     (rsp_if.data_byte),
      .rsp_trim_overflow (rsp_if.trim_overflow),
      .rsp_last_of_run   (rsp_if.last_of_run)
   );

endmodule
